// ----- hdl/tpe_pkg.sv -----
// Shared constants, codes and controller/datapath handshake types for the parameter expander.
package tpe_pkg;

	localparam int NUM_PARAMS = 9;
	localparam int OUT_LIMIT  = 255;
	localparam int SEL_W      = $clog2(NUM_PARAMS);
	localparam int CNT_W      = 8;
	localparam int MAG_W      = 32;
	localparam int DEC_DIGITS = 10;
	localparam int BCD_W      = 4 * DEC_DIGITS;
	localparam int CONV_STEPS = MAG_W;
	localparam int STEP_W     = $clog2(CONV_STEPS);
	localparam int DIG_W      = $clog2(DEC_DIGITS);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_PERCENT = 2'd1;
	localparam logic [1:0] MODE_SELECT  = 2'd2;

	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_CHAR     = 3'd1;
	localparam logic [2:0] ACT_PCT      = 3'd2;
	localparam logic [2:0] ACT_PCT_CHAR = 3'd3;
	localparam logic [2:0] ACT_LOW      = 3'd4;
	localparam logic [2:0] ACT_DEC      = 3'd5;

	localparam logic [2:0] SRC_CHAR  = 3'd0;
	localparam logic [2:0] SRC_PCT   = 3'd1;
	localparam logic [2:0] SRC_LOW   = 3'd2;
	localparam logic [2:0] SRC_MINUS = 3'd3;
	localparam logic [2:0] SRC_DIGIT = 3'd4;
	localparam logic [2:0] SRC_TERM  = 3'd5;

	typedef struct packed {
		logic       capture;
		logic       decode;
		logic       emit;
		logic [2:0] emit_src;
		logic       emit_final;
		logic       conv_step;
		logic       digit_next;
		logic       restart;
	} cmd_t;

	typedef struct packed {
		logic       in_op;
		logic [2:0] action;
		logic       neg;
		logic       conv_last;
		logic       digit_skip;
		logic       digit_final;
		logic       out_busy;
		logic       eot;
	} status_t;

endpackage

// ----- hdl/tpe_if.sv -----
// Valid/ready channel interfaces for format items and expanded result characters.
interface tpe_item_if import tpe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [3:0]         param_index;
	logic signed [31:0] param_value;
	logic [7:0]         format_char;
	logic               end_of_text;

	modport source (output valid, op, param_index, param_value, format_char, end_of_text,
		input ready);
	modport sink (input valid, op, param_index, param_value, format_char, end_of_text,
		output ready);
endinterface

interface tpe_result_if import tpe_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       is_terminator;
	logic       last;

	modport source (output valid, out_char, is_terminator, last, input ready);
	modport sink (input valid, out_char, is_terminator, last, output ready);
endinterface

// ----- hdl/tpe_datapath.sv -----
// Datapath: parameter store, escape state, binary to decimal converter and output register.
module tpe_datapath import tpe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic               op,
	input  logic [3:0]         param_index,
	input  logic signed [31:0] param_value,
	input  logic [7:0]         format_char,
	input  logic               end_of_text,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               is_terminator,
	output logic               last
);

	logic [MAG_W-1:0] param_q [NUM_PARAMS];
	logic [1:0]       mode_q;
	logic [SEL_W-1:0] sel_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       char_q;
	logic             eot_q;
	logic [MAG_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic             neg_q;
	logic [STEP_W-1:0] step_q;
	logic [DIG_W-1:0] dig_q;
	logic             started_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_term_q;
	logic             out_last_q;

	logic [2:0]       act;
	logic [2:0]       n_act;
	logic [1:0]       mode_nx;
	logic [1:0]       n_mode;
	logic             sel_wr;
	logic             do_inc;
	logic             limit;
	logic [3:0]       digit_k;
	logic [MAG_W-1:0] sel_val;
	logic [MAG_W-1:0] mag;
	logic [BCD_W-1:0] bcd_adj;
	logic [3:0]       top_digit;
	logic             is_term;
	logic             emit_ok;
	logic [7:0]       emit_char;
	logic             emit_last;
	logic             digit_final;
	logic             digit_skip;
	logic             load_item;

	assign limit     = count_q >= CNT_W'(OUT_LIMIT);
	assign digit_k   = char_q[3:0] - 4'd1;
	assign sel_val   = param_q[sel_q];
	assign mag       = sel_val[MAG_W-1] ? (MAG_W'(0) - sel_val) : sel_val;
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign load_item = cmd.capture && !op;

	always_comb begin
		n_act   = (char_q == CH_PCT || char_q == CH_NUL) ? ACT_NONE : ACT_CHAR;
		n_mode  = (char_q == CH_PCT) ? MODE_PERCENT : MODE_NORMAL;
		act     = ACT_NONE;
		mode_nx = MODE_NORMAL;
		sel_wr  = 1'b0;
		do_inc  = 1'b0;
		case (mode_q)
			MODE_SELECT: begin
				if (char_q inside {[CH_ONE:CH_NINE]}) begin
					sel_wr = digit_k < 4'(NUM_PARAMS);
				end else begin
					act     = n_act;
					mode_nx = n_mode;
				end
			end
			MODE_PERCENT: begin
				case (char_q)
					CH_D:    act = ACT_DEC;
					CH_C:    act = ACT_LOW;
					CH_I:    do_inc = 1'b1;
					CH_P:    mode_nx = MODE_SELECT;
					CH_PCT:  act = ACT_PCT;
					CH_NUL:  act = ACT_NONE;
					default: act = ACT_PCT_CHAR;
				endcase
			end
			default: begin
				act     = n_act;
				mode_nx = n_mode;
			end
		endcase
		if (limit) begin
			act = ACT_NONE;
		end
	end

	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	assign digit_final = dig_q == DIG_W'(DEC_DIGITS - 1);
	assign digit_skip  = !started_q && top_digit == 4'd0 && !digit_final;

	always_comb begin
		case (cmd.emit_src)
			SRC_CHAR:  emit_char = char_q;
			SRC_PCT:   emit_char = CH_PCT;
			SRC_LOW:   emit_char = sel_val[7:0];
			SRC_MINUS: emit_char = CH_MINUS;
			SRC_DIGIT: emit_char = CH_ZERO | {4'd0, top_digit};
			default:   emit_char = CH_NUL;
		endcase
	end

	assign is_term   = cmd.emit_src == SRC_TERM;
	assign emit_ok   = cmd.emit && (is_term || !limit);
	assign emit_last = is_term
		|| (!eot_q && (cmd.emit_final || count_q == CNT_W'(OUT_LIMIT - 1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PARAMS; i++) begin
				param_q[i] <= '0;
			end
		end else begin
			if (load_item && param_index < 4'(NUM_PARAMS)) begin
				param_q[param_index[SEL_W-1:0]] <= param_value;
			end else if (cmd.decode && !limit && do_inc) begin
				param_q[0] <= param_q[0] + MAG_W'(1);
				param_q[1] <= param_q[1] + MAG_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			sel_q   <= '0;
			count_q <= '0;
		end else if (load_item || cmd.restart) begin
			mode_q  <= MODE_NORMAL;
			sel_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.decode && !limit) begin
				mode_q <= mode_nx;
				if (sel_wr) begin
					sel_q <= digit_k[SEL_W-1:0];
				end
			end
			if (emit_ok && !is_term) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ok) begin
			out_char_q <= emit_char;
			out_term_q <= is_term;
			out_last_q <= emit_last;
		end
		if (cmd.capture) begin
			char_q <= format_char;
			eot_q  <= end_of_text;
		end
		if (cmd.decode && act == ACT_DEC) begin
			bin_q     <= mag;
			neg_q     <= sel_val[MAG_W-1];
			bcd_q     <= '0;
			step_q    <= '0;
			dig_q     <= '0;
			started_q <= 1'b0;
		end else if (cmd.conv_step) begin
			bcd_q  <= {bcd_adj[BCD_W-2:0], bin_q[MAG_W-1]};
			bin_q  <= {bin_q[MAG_W-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
		end else if (cmd.digit_next) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			dig_q <= dig_q + DIG_W'(1);
			if (!digit_skip) begin
				started_q <= 1'b1;
			end
		end
	end

	assign status.in_op       = op;
	assign status.action      = act;
	assign status.neg         = neg_q;
	assign status.conv_last   = step_q == STEP_W'(CONV_STEPS - 1);
	assign status.digit_skip  = digit_skip;
	assign status.digit_final = digit_final;
	assign status.out_busy    = out_valid_q && !out_ready;
	assign status.eot         = eot_q;

	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign is_terminator = out_term_q;
	assign last          = out_last_q;

endmodule

// ----- hdl/tpe_controller.sv -----
// Controller state machine that sequences each format item through the datapath.
module tpe_controller import tpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output cmd_t    cmd,
	input  status_t status
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_PCT1   = 4'd2;
	localparam logic [3:0] S_PCT    = 4'd3;
	localparam logic [3:0] S_CHAR   = 4'd4;
	localparam logic [3:0] S_LOW    = 4'd5;
	localparam logic [3:0] S_CONV   = 4'd6;
	localparam logic [3:0] S_MINUS  = 4'd7;
	localparam logic [3:0] S_DIGIT  = 4'd8;
	localparam logic [3:0] S_TERM   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic [3:0] done_nx;

	assign done_nx = status.eot ? S_TERM : S_IDLE;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (status.in_op) begin
						state_nx = S_DECODE;
					end
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				case (status.action)
					ACT_CHAR:     state_nx = S_CHAR;
					ACT_PCT:      state_nx = S_PCT;
					ACT_PCT_CHAR: state_nx = S_PCT1;
					ACT_LOW:      state_nx = S_LOW;
					ACT_DEC:      state_nx = S_CONV;
					default:      state_nx = done_nx;
				endcase
			end
			S_PCT1: begin
				if (!status.out_busy) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = SRC_PCT;
					state_nx     = S_CHAR;
				end
			end
			S_PCT: begin
				if (!status.out_busy) begin
					cmd.emit       = 1'b1;
					cmd.emit_src   = SRC_PCT;
					cmd.emit_final = 1'b1;
					state_nx       = done_nx;
				end
			end
			S_CHAR: begin
				if (!status.out_busy) begin
					cmd.emit       = 1'b1;
					cmd.emit_src   = SRC_CHAR;
					cmd.emit_final = 1'b1;
					state_nx       = done_nx;
				end
			end
			S_LOW: begin
				if (!status.out_busy) begin
					cmd.emit       = 1'b1;
					cmd.emit_src   = SRC_LOW;
					cmd.emit_final = 1'b1;
					state_nx       = done_nx;
				end
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (status.conv_last) begin
					state_nx = status.neg ? S_MINUS : S_DIGIT;
				end
			end
			S_MINUS: begin
				if (!status.out_busy) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = SRC_MINUS;
					state_nx     = S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (status.digit_skip) begin
					cmd.digit_next = 1'b1;
				end else if (!status.out_busy) begin
					cmd.emit       = 1'b1;
					cmd.emit_src   = SRC_DIGIT;
					cmd.emit_final = status.digit_final;
					cmd.digit_next = 1'b1;
					if (status.digit_final) begin
						state_nx = done_nx;
					end
				end
			end
			S_TERM: begin
				if (!status.out_busy) begin
					cmd.emit     = 1'b1;
					cmd.emit_src = SRC_TERM;
					cmd.restart  = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ----- hdl/terminfo_param_expander_core.sv -----
// Top level of the terminfo parameter expander: controller and datapath.
//
//   Channel      Modport   Transaction
//   item_in      sink      parameter load or one format character
//   result_out   source    one expanded character, or the closing zero byte
//
// A load is captured in idle; a format character is captured, decoded, then emits each of its bytes.
// Percent-d runs a 32-bit shift-and-add-three converter, then scans ten digit positions,
// one per cycle unless result_out stalls a digit; a closing zero byte follows when end_of_text is set.
// Every emitted byte waits in the output register while result_out is stalled; the next
// item is accepted as soon as the last byte of the current one has been loaded there.
// Reset clears the parameters and the escape state at once.
module terminfo_param_expander_core import tpe_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	tpe_item_if.sink   item_in,
	tpe_result_if.source result_out
);

	cmd_t    cmd;
	status_t status;

	tpe_controller u_controller (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (item_in.ready),
		.cmd      (cmd),
		.status   (status)
	);

	tpe_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.op            (item_in.op),
		.param_index   (item_in.param_index),
		.param_value   (item_in.param_value),
		.format_char   (item_in.format_char),
		.end_of_text   (item_in.end_of_text),
		.out_valid     (result_out.valid),
		.out_ready     (result_out.ready),
		.out_char      (result_out.out_char),
		.is_terminator (result_out.is_terminator),
		.last          (result_out.last)
	);

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the terminfo parameter expander.
module tb_top;
	import tpe_pkg::*;

	localparam logic OP_LOAD       = 1'b0;
	localparam logic OP_CHAR       = 1'b1;
	localparam int   MAX_PER_ITEM  = 12;
	localparam int   SETTLE_CYCLES = 60;
	localparam int   RANDOM_ITEMS  = 240;

	typedef struct packed {
		logic [7:0] ch;
		logic       term;
		logic       last;
	} char_result_t;

	logic clk;
	logic arst_n;

	tpe_item_if   item_if();
	tpe_result_if result_if();

	terminfo_param_expander_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (result_if)
	);

	logic [31:0]  params [NUM_PARAMS];
	logic [1:0]   esc_mode;
	logic [3:0]   sel_idx;
	int           out_count;
	char_result_t item_chars[$];
	char_result_t expected_chars[$];
	int           mismatches = 0;
	int           items_sent = 0;
	bit           full_rate  = 1'b0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void restart_string();
		esc_mode  = MODE_NORMAL;
		sel_idx   = '0;
		out_count = 0;
	endfunction

	function automatic void put_char(logic [7:0] c);
		char_result_t r;
		if (out_count < OUT_LIMIT && item_chars.size() < MAX_PER_ITEM) begin
			r.ch   = c;
			r.term = 1'b0;
			r.last = 1'b0;
			item_chars.push_back(r);
			out_count++;
		end
	endfunction

	function automatic void put_decimal(logic [31:0] v);
		logic [7:0]  digs [10];
		logic [31:0] mag;
		int          nd;
		nd  = 0;
		mag = v;
		if (v[31]) begin
			put_char(CH_MINUS);
			mag = -v;
		end
		do begin
			digs[nd] = CH_ZERO + 8'(mag % 32'd10);
			nd++;
			mag = mag / 32'd10;
		end while (mag != 0 && nd < 10);
		while (nd > 0) begin
			nd--;
			put_char(digs[nd]);
		end
	endfunction

	function automatic void plain_char(logic [7:0] c);
		if (c == CH_PCT) begin
			esc_mode = MODE_PERCENT;
		end else if (c != CH_NUL) begin
			put_char(c);
		end
	endfunction

	function automatic void format_step(logic [7:0] c);
		logic [31:0] v;
		v = (sel_idx < NUM_PARAMS) ? params[sel_idx] : '0;
		if (esc_mode == MODE_SELECT) begin
			esc_mode = MODE_NORMAL;
			if (c >= CH_ONE && c <= CH_NINE) begin
				if (c - CH_ONE < NUM_PARAMS)
					sel_idx = 4'(c - CH_ONE);
			end else begin
				plain_char(c);
			end
		end else if (esc_mode == MODE_PERCENT) begin
			esc_mode = MODE_NORMAL;
			case (c)
				CH_D: put_decimal(v);
				CH_C: put_char(v[7:0]);
				CH_I: begin
					params[0] = params[0] + 32'd1;
					params[1] = params[1] + 32'd1;
				end
				CH_P: esc_mode = MODE_SELECT;
				CH_PCT: put_char(CH_PCT);
				CH_NUL: ;
				default: begin
					put_char(CH_PCT);
					put_char(c);
				end
			endcase
		end else begin
			plain_char(c);
		end
	endfunction

	// Works out the characters that one accepted transaction produces.
	function automatic void expand_item(logic op, logic [3:0] idx, logic [31:0] val,
		logic [7:0] c, logic eot);
		char_result_t r;
		item_chars.delete();
		if (op == OP_LOAD) begin
			if (idx < NUM_PARAMS)
				params[idx] = val;
			restart_string();
		end else begin
			if (out_count < OUT_LIMIT)
				format_step(c);
			if (eot) begin
				if (item_chars.size() < MAX_PER_ITEM) begin
					r.ch   = CH_NUL;
					r.term = 1'b1;
					r.last = 1'b0;
					item_chars.push_back(r);
				end
				restart_string();
			end
			foreach (item_chars[k]) begin
				r      = item_chars[k];
				r.last = (k == item_chars.size() - 1);
				expected_chars.push_back(r);
			end
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (full_rate)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(2, 1);
		if (r < 96)
			return $urandom_range(6, 3);
		return $urandom_range(30, 10);
	endfunction

	function automatic logic [31:0] random_value();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			1: return 32'($urandom_range(40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] random_plain();
		logic [7:0] c;
		c = 8'($urandom_range(255, 1));
		if (c == CH_PCT)
			c = CH_MINUS;
		return c;
	endfunction

	task automatic send_item(logic op, logic [3:0] idx, logic [31:0] val, logic [7:0] c,
		logic eot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid       <= 1'b1;
		item_if.op          <= op;
		item_if.param_index <= idx;
		item_if.param_value <= val;
		item_if.format_char <= c;
		item_if.end_of_text <= eot;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		items_sent++;
		expand_item(op, idx, val, c, eot);
	endtask

	task automatic load_param(logic [3:0] idx, logic [31:0] val);
		send_item(OP_LOAD, idx, val, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_char(logic [7:0] c, logic eot);
		send_item(OP_CHAR, 4'($urandom), $urandom, c, eot);
	endtask

	task automatic send_escape(logic [7:0] c, logic eot);
		send_char(CH_PCT, 1'b0);
		send_char(c, eot);
	endtask

	task automatic wait_drain();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_param_extremes();
		load_param(4'd8, 32'h7fff_ffff);
		load_param(4'd2, 32'h0000_0100);
		load_param(4'd15, 32'h5a5a_5a5a);
		send_escape(CH_P, 1'b0);
		send_char(CH_NINE, 1'b0);
		send_escape(CH_D, 1'b0);
		send_escape(CH_P, 1'b0);
		send_char(CH_ONE + 8'd2, 1'b0);
		send_escape(CH_C, 1'b1);
		wait_drain();
	endtask

	task automatic test_escapes();
		send_escape(CH_PCT, 1'b0);
		send_escape("z", 1'b0);
		send_escape(CH_P, 1'b0);
		send_char("x", 1'b0);
		send_escape(CH_NUL, 1'b0);
		send_char(8'hff, 1'b0);
		send_char(CH_PCT, 1'b1);
		send_escape(CH_P, 1'b1);
		wait_drain();
	endtask

	task automatic test_increment_wrap();
		load_param(4'd0, 32'hffff_ffff);
		load_param(4'd1, 32'h7fff_ffff);
		send_escape(CH_I, 1'b0);
		send_escape(CH_D, 1'b0);
		send_escape(CH_P, 1'b0);
		send_char(CH_ONE + 8'd1, 1'b0);
		send_escape(CH_D, 1'b1);
		wait_drain();
	endtask

	// Eleven characters per number, so the limit falls part-way through the last of the 24 repeated ones.
	task automatic test_output_limit();
		full_rate = 1'b1;
		load_param(4'd0, 32'h8000_0000 + 32'($urandom_range(1147483647)));
		repeat (24) send_escape(CH_D, 1'b0);
		send_char("a", 1'b0);
		send_escape(CH_D, 1'b0);
		full_rate = 1'b0;
		send_char("b", 1'b1);
		wait_drain();
	endtask

	task automatic test_random_strings();
		int stop_at;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(9) < 3) begin
				repeat ($urandom_range(3, 1)) begin
					if ($urandom_range(9) == 0)
						load_param(4'($urandom_range(15, NUM_PARAMS)), random_value());
					else
						load_param(4'($urandom_range(NUM_PARAMS - 1)), random_value());
				end
			end
			full_rate = ($urandom_range(7) == 0);
			repeat ($urandom_range(8, 1)) begin
				case ($urandom_range(9))
					0, 1, 2: send_char(random_plain(), 1'b0);
					3: send_escape(CH_D, 1'b0);
					4: send_escape(CH_C, 1'b0);
					5: send_escape(CH_I, 1'b0);
					6: begin
						send_escape(CH_P, 1'b0);
						send_char(CH_ONE + 8'($urandom_range(8)), 1'b0);
					end
					7: send_escape(CH_PCT, 1'b0);
					8: begin
						send_escape(CH_P, 1'b0);
						send_char(8'($urandom_range(255)), 1'b0);
					end
					default: send_escape(8'($urandom_range(255)), 1'b0);
				endcase
			end
			if ($urandom_range(9) != 0)
				send_char(8'($urandom_range(255)), 1'b1);
			if ($urandom_range(11) == 0)
				wait_drain();
		end
		full_rate = 1'b0;
	endtask

	initial begin
		int stall;
		char_result_t want;
		result_if.ready <= 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_if.valid && result_if.ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected result char=%02h term=%b last=%b", $time,
						result_if.out_char, result_if.is_terminator, result_if.last);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (result_if.out_char !== want.ch) begin
						$display("%0t: out_char expected %02h actual %02h", $time, want.ch,
							result_if.out_char);
						mismatches++;
					end
					if (result_if.is_terminator !== want.term) begin
						$display("%0t: is_terminator expected %b actual %b", $time, want.term,
							result_if.is_terminator);
						mismatches++;
					end
					if (result_if.last !== want.last) begin
						$display("%0t: last expected %b actual %b", $time, want.last,
							result_if.last);
						mismatches++;
					end
				end
			end
			if (stall == 0 && $urandom_range(2) == 0)
				stall = pick_gap();
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				stall--;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		#(10_000_000);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		arst_n                <= 1'b0;
		item_if.valid         <= 1'b0;
		item_if.op            <= OP_LOAD;
		item_if.param_index   <= '0;
		item_if.param_value   <= '0;
		item_if.format_char   <= CH_NUL;
		item_if.end_of_text   <= 1'b0;
		foreach (params[k])
			params[k] = '0;
		restart_string();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_param_extremes();
		test_escapes();
		test_increment_wrap();
		test_output_limit();
		test_random_strings();
		wait_drain();
		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
